### design/key_click_classifier_defines.svh
// Assertion helpers for the key click classifier.
// Clocked on clk, switched off while arst_n is low.
`ifndef KEY_CLICK_CLASSIFIER_DEFINES_SVH
`define KEY_CLICK_CLASSIFIER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/kcc_pkg.sv
package kcc_pkg;

	// Key count and configuration widths are fixed by the port list
	localparam int NUM_KEYS  = 6;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_WINDOW = 2'd1;

	// Configuration reset values
	localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 8'd70;
	localparam logic [CFG_W-1:0] CLICK_WINDOW_RST = 8'd35;

	// Debounce phase of one key
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_CONFIRM = 2'd1,
		PH_HELD    = 2'd2
	} phase_t;

	// Event code reported per key
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SHORT  = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} ev_t;

	// All keys' event codes side by side
	typedef ev_t [NUM_KEYS-1:0] ev_vec_t;

	// What one lane reports for the tick being accepted
	typedef struct packed {
		ev_t  event_code;
		logic changed;
	} lane_res_t;

endpackage

### design/key_click_classifier.sv
// Key click classifier: six debounced keys, click, double, long classification.
// A result is registered in the output buffer before it appears on the output.
// Throughput: one tick per cycle while in_stall is low; each key has its own lane.
// A two-entry output buffer lets ticks flow while a result waits to be taken.
// Reset (asynchronous, active low) idles all keys, clears timers and events,
// and loads the thresholds with 70 and 35.
`include "key_click_classifier_defines.svh"

module key_click_classifier #(
	parameter int TIMER_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [5:0]                  key_levels,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  event_key0,
	output logic [1:0]                  event_key1,
	output logic [1:0]                  event_key2,
	output logic [1:0]                  event_key3,
	output logic [1:0]                  event_key4,
	output logic [1:0]                  event_key5,
	input  logic                        cfg_we,
	input  logic [kcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kcc_pkg::CFG_W-1:0]   cfg_data
);
	import kcc_pkg::*;

	logic [CFG_W-1:0]     long_press_q, click_window_q;
	lane_res_t            lane_res [NUM_KEYS];
	ev_vec_t              ev_next, ev_out;
	logic [NUM_KEYS-1:0]  chg;
	logic                 in_acc, any_change;

	assign in_acc = in_valid & ~in_stall;

	// Threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q   <= LONG_PRESS_RST;
			click_window_q <= CLICK_WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_PRESS:   long_press_q   <= cfg_data;
				REG_CLICK_WINDOW: click_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// One lane per key
	for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
		kcc_lane #(
			.TIMER_BITS(TIMER_BITS)
		) u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (in_acc),
			.key_level   (key_levels[g]),
			.long_press  (long_press_q),
			.click_window(click_window_q),
			.res         (lane_res[g])
		);
		assign ev_next[g] = lane_res[g].event_code;
		assign chg[g]     = lane_res[g].changed;
	end

	// A result goes out only when some key's code moved
	assign any_change = |chg;

	kcc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc & any_change),
		.events_in (ev_next),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.events_out(ev_out),
		.in_stall  (in_stall)
	);

	assign event_key0 = ev_out[0];
	assign event_key1 = ev_out[1];
	assign event_key2 = ev_out[2];
	assign event_key3 = ev_out[3];
	assign event_key4 = ev_out[4];
	assign event_key5 = ev_out[5];

	// Checks
	`KCC_ASSERT_NOW(a_skid_behind_main, in_stall, out_valid, "skid full with output empty")
	`KCC_ASSERT_NEXT(a_change_shows, in_acc && any_change, out_valid, "changed tick gave no result")
	`KCC_ASSERT_NEXT(a_no_fill_on_drain, out_valid && !out_stall && !in_stall, !in_stall, "skid filled while output drained")

endmodule

### design/kcc_lane.sv
module kcc_lane #(
	parameter int TIMER_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    key_level,
	input  logic [kcc_pkg::CFG_W-1:0] long_press,
	input  logic [kcc_pkg::CFG_W-1:0] click_window,
	output kcc_pkg::lane_res_t      res
);
	import kcc_pkg::*;

	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	phase_t                phase_q, phase_n;
	logic [TIMER_BITS-1:0] hold_q, hold_n;
	logic                  wopen_q, wopen_a, wopen_n;
	logic [TIMER_BITS-1:0] wcnt_q, wcnt_a, wcnt_n;
	ev_t                   ev_q, ev_a, ev_n;
	logic                  pressed;
	logic [CMP_W-1:0]      hold_x, long_x, wcnt_x, win_x;

	assign pressed = ~key_level;
	assign hold_x  = CMP_W'(hold_q);
	assign long_x  = CMP_W'(long_press);
	assign win_x   = CMP_W'(click_window);

	// Debounce phase: next state
	always_comb begin
		case (phase_q)
			PH_CONFIRM: phase_n = pressed ? PH_HELD : PH_IDLE;
			PH_HELD:    phase_n = pressed ? PH_HELD : PH_IDLE;
			default:    phase_n = pressed ? PH_CONFIRM : PH_IDLE;
		endcase
	end

	// Hold timer, click window and event per phase
	always_comb begin
		hold_n  = hold_q;
		wopen_a = wopen_q;
		wcnt_a  = wcnt_q;
		ev_a    = ev_q;
		case (phase_q)
			PH_CONFIRM: begin
			end
			PH_HELD: begin
				if (!pressed) begin
					if (hold_x < long_x) begin
						if (!wopen_q) begin
							wopen_a = 1'b1;
							wcnt_a  = '0;
						end else begin
							ev_a    = EV_DOUBLE;
							wopen_a = 1'b0;
						end
					end
				end else begin
					if (hold_x > long_x)
						ev_a = EV_LONG;
					hold_n = (hold_q == TIMER_MAX) ? TIMER_MAX : hold_q + 1'b1;
				end
			end
			default: begin
				if (pressed)
					hold_n = '0;
				else
					ev_a = EV_NONE;
			end
		endcase
	end

	// Window run-out: count on and report short once past the threshold
	assign wcnt_x = CMP_W'(wcnt_n);
	always_comb begin
		wopen_n = wopen_a;
		wcnt_n  = wcnt_a;
		ev_n    = ev_a;
		if (wopen_a) begin
			wcnt_n = (wcnt_a == TIMER_MAX) ? TIMER_MAX : wcnt_a + 1'b1;
		end
		if (wopen_a && (wcnt_x > win_x)) begin
			ev_n    = EV_SHORT;
			wopen_n = 1'b0;
		end
	end

	// Lane state, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hold_q  <= '0;
			wopen_q <= 1'b0;
			wcnt_q  <= '0;
			ev_q    <= EV_NONE;
		end else if (adv) begin
			phase_q <= phase_n;
			hold_q  <= hold_n;
			wopen_q <= wopen_n;
			wcnt_q  <= wcnt_n;
			ev_q    <= ev_n;
		end
	end

	assign res.event_code = ev_n;
	assign res.changed    = (ev_n != ev_q);

endmodule

### design/kcc_merge.sv
module kcc_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kcc_pkg::ev_vec_t events_in,
	input  logic             out_stall,
	output logic             out_valid,
	output kcc_pkg::ev_vec_t events_out,
	output logic             in_stall
);
	import kcc_pkg::*;

	logic    main_v_q, skid_v_q;
	ev_vec_t main_q, skid_q;
	logic    out_fire;

	assign out_fire   = main_v_q & ~out_stall;
	assign out_valid  = main_v_q;
	assign events_out = main_q;
	assign in_stall   = skid_v_q;

	// Output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_fire) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_v_q || out_fire)
				main_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (out_fire) begin
			main_v_q <= 1'b0;
		end
	end

	// Payload moves follow the same decisions
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_fire)
				main_q <= skid_q;
		end else if (push) begin
			if (!main_v_q || out_fire)
				main_q <= events_in;
			else
				skid_q <= events_in;
		end
	end

endmodule
